// ----- hdl/mvma_pkg.sv -----
// shared types, constants and state codes for the matrix-vector multiply-add unit
package mvma_pkg;

  localparam int DATA_W  = 32;                // Q16.16 operands and result
  localparam int ACC_W   = 64;                // Q48.16 row accumulator
  localparam int OP_W    = DATA_W + 1;        // multiplier operand, room for unsigned low word
  localparam int PROD_W  = 2 * OP_W;          // full product width
  localparam int FRAC_W  = 16;                // fraction bits
  localparam int MV_W    = 2 * DATA_W - FRAC_W;       // m*v after the shift
  localparam int AL_W    = DATA_W + DATA_W + 1 - FRAC_W; // alpha*lo after the shift
  localparam int REST_W  = AL_W + 1;          // sum of the two shifted low parts
  localparam int AH_W    = DATA_W + 2;        // alpha*hi once known to be in range
  localparam int FIN_W   = AH_W + FRAC_W + 2; // final sum before clamping
  localparam int CFG_IDX_W = 2;

  typedef logic signed [OP_W-1:0]   mul_op_t;
  typedef logic signed [PROD_W-1:0] mul_prod_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t IDX_ALPHA = 2'd0;
  localparam cfg_idx_t IDX_BETA  = 2'd1;

  localparam logic signed [DATA_W-1:0] ALPHA_RST = 32'sd65536;
  localparam logic signed [DATA_W-1:0] BETA_RST  = 32'sd0;

  localparam logic signed [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // alpha*hi beyond +/- 2^32 always clamps the result
  localparam mul_prod_t AH_HI_LIM = mul_prod_t'(66'sh1_0000_0000);
  localparam mul_prod_t AH_LO_LIM = -mul_prod_t'(66'sh1_0000_0000);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_AH,
    S_AL,
    S_BB,
    S_RST,
    S_OUT
  } seq_state_t;

endpackage

// ----- hdl/mvma_mul.sv -----
// shared signed multiplier with a registered product
module mvma_mul (
  input  logic               clk,
  input  logic               en,
  input  mvma_pkg::mul_op_t  op_a,
  input  mvma_pkg::mul_op_t  op_b,
  output mvma_pkg::mul_prod_t prod_r
);
  import mvma_pkg::*;

  mul_prod_t prod_nxt;

  // full-width signed product
  assign prod_nxt = op_a * op_b;

  // product register, loaded only when the sequencer asks
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- hdl/matrix_vector_multiply_add_unit.sv -----
// top level: row-at-a-time alpha*M*v + beta*b with a shared multiplier
//
//  channel  dir  handshake          payload
//  in_      in   tvalid / tready    tdata: matrix, vector, bias; tlast: end of row
//  out_     out  tvalid / tready    tdata: row result; tuser: saturated flag
//  cfg_     in   valid / ready      index, data (0 alpha_gain, 1 beta_gain)
//
// an item that does not end a row is multiplied, then accumulated
// an item that ends a row is also accumulated, then the one multiplier runs three more
// products (alpha*hi, alpha*lo, beta*bias), then two add steps form the result
// in_tready is low while a request is in work and while a result waits to load
// the output register; a held result does not block a non-final request
// reset (rst_n low, synchronous) restores gains, clears the row and the output
module matrix_vector_multiply_add_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input requests
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,  // [31:0] matrix_element,
                                                    // [63:32] vector_element,
                                                    // [95:64] bias_element
  input  logic                           in_tlast,
  // results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata, // [31:0] row_result
  output logic [0:0]                     out_tuser, // [0] saturated
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  mvma_pkg::cfg_idx_t             cfg_index,
  input  logic [31:0]                    cfg_data
);
  import mvma_pkg::*;

  seq_state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] alpha_r, alpha_nxt;
  logic signed [DATA_W-1:0] beta_r, beta_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic signed [DATA_W-1:0] bias_r, bias_nxt;
  logic                     last_r, last_nxt;
  logic                     ah_hi_r, ah_hi_nxt;
  logic                     ah_lo_r, ah_lo_nxt;
  logic signed [AH_W-1:0]   ah_r, ah_nxt;
  logic signed [REST_W-1:0] rest_r, rest_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_res_r, out_res_nxt;
  logic                     out_sat_r, out_sat_nxt;

  mul_op_t   mul_a, mul_b;
  logic      mul_en;
  mul_prod_t prod_r;

  logic                     in_acc;
  logic                     out_free;
  logic signed [MV_W-1:0]   mv_shift;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [FIN_W-1:0]  fin_sum;
  logic                     fin_over;
  logic                     fin_under;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_sat_r;

  // shared multiplier
  mvma_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // floor-shifted m*v and the widened accumulator sum
  assign mv_shift = prod_r[2*DATA_W-1:FRAC_W];
  assign acc_sum  = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(mv_shift);

  // final sum: alpha*hi scaled up plus the shifted low parts
  assign fin_sum   = FIN_W'(signed'({ah_r, {FRAC_W{1'b0}}})) + FIN_W'(rest_r);
  assign fin_over  = ~fin_sum[FIN_W-1] & (|fin_sum[FIN_W-2:DATA_W-1]);
  assign fin_under = fin_sum[FIN_W-1] & ~(&fin_sum[FIN_W-2:DATA_W-1]);

  // sequencer: next state, operand selection and register updates
  always_comb begin
    state_nxt     = state_r;
    alpha_nxt     = alpha_r;
    beta_nxt      = beta_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    bias_nxt      = bias_r;
    last_nxt      = last_r;
    ah_hi_nxt     = ah_hi_r;
    ah_lo_nxt     = ah_lo_r;
    ah_nxt        = ah_r;
    rest_nxt      = rest_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_res_nxt   = out_res_r;
    out_sat_nxt   = out_sat_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    // configuration writes, other indexes ignored
    if (cfg_valid) begin
      if (cfg_index == IDX_ALPHA) begin
        alpha_nxt = cfg_data;
      end else if (cfg_index == IDX_BETA) begin
        beta_nxt = cfg_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        mul_a = OP_W'(signed'(in_tdata[31:0]));
        mul_b = OP_W'(signed'(in_tdata[63:32]));
        if (in_acc) begin
          mul_en    = 1'b1;
          bias_nxt  = in_tdata[95:64];
          last_nxt  = in_tlast;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        // saturating accumulate
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
          acc_nxt = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = acc_sum[ACC_W-1:0];
        end
        state_nxt = last_r ? S_AH : S_IDLE;
      end
      S_AH: begin
        // alpha times the signed high word
        mul_en    = 1'b1;
        mul_a     = OP_W'(alpha_r);
        mul_b     = OP_W'(signed'(acc_r[ACC_W-1:DATA_W]));
        state_nxt = S_AL;
      end
      S_AL: begin
        // alpha times the unsigned low word; classify alpha*hi
        mul_en    = 1'b1;
        mul_a     = OP_W'(alpha_r);
        mul_b     = {1'b0, acc_r[DATA_W-1:0]};
        ah_hi_nxt = (prod_r > AH_HI_LIM);
        ah_lo_nxt = (prod_r < AH_LO_LIM);
        ah_nxt    = prod_r[AH_W-1:0];
        state_nxt = S_BB;
      end
      S_BB: begin
        // beta times bias; keep floor-shifted alpha*lo
        mul_en    = 1'b1;
        mul_a     = OP_W'(beta_r);
        mul_b     = OP_W'(bias_r);
        rest_nxt  = REST_W'(signed'(prod_r[2*DATA_W:FRAC_W]));
        state_nxt = S_RST;
      end
      S_RST: begin
        rest_nxt  = rest_r + REST_W'(mv_shift);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // clamp and load the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          priority if (ah_hi_r) begin
            out_res_nxt = RES_MAX;
          end else if (ah_lo_r) begin
            out_res_nxt = RES_MIN;
          end else if (fin_over) begin
            out_res_nxt = RES_MAX;
          end else if (fin_under) begin
            out_res_nxt = RES_MIN;
          end else begin
            out_res_nxt = fin_sum[DATA_W-1:0];
          end
          out_sat_nxt = ovf_r | ah_hi_r | ah_lo_r | fin_over | fin_under;
          acc_nxt     = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RST;
      beta_r      <= BETA_RST;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      alpha_r     <= alpha_nxt;
      beta_r      <= beta_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bias_r    <= bias_nxt;
    last_r    <= last_nxt;
    ah_hi_r   <= ah_hi_nxt;
    ah_lo_r   <= ah_lo_nxt;
    ah_r      <= ah_nxt;
    rest_r    <= rest_nxt;
    out_res_r <= out_res_nxt;
    out_sat_r <= out_sat_nxt;
  end

`ifndef SYNTHESIS
  // an accepted request always goes to the accumulate step next
  a_acc_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_ACC)
    else $error("request not followed by accumulate step");

  // a request that does not end a row frees the input once the accumulate step is done
  a_mid_row_rate: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> ##1 in_tready)
    else $error("mid-row request held the input too long");

  // loading a result clears the row state
  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> acc_r == '0 && !ovf_r && out_valid_r)
    else $error("row state not cleared after result");

  // a clamped final value always raises the flag
  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free && (ah_hi_r || ah_lo_r || fin_over || fin_under)
    |=> out_sat_r)
    else $error("clamped result without saturated flag");
`endif

endmodule

// ----- tb/tb_matrix_vector_multiply_add_unit.sv -----
// self-checking testbench for the matrix-vector multiply-add unit
module tb_matrix_vector_multiply_add_unit;
  import mvma_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_ROW_LEN  = 40;  // enough large m*v terms to grow the high word

  // gain register indexes that the block must ignore
  localparam cfg_idx_t IDX_SPARE_A = 2'd2;
  localparam cfg_idx_t IDX_SPARE_B = 2'd3;

  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;

  typedef struct packed {
    logic signed [31:0] row_result;
    logic               saturated;
  } row_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = IDX_ALPHA;
  logic [31:0] cfg_data = '0;

  // predictor state: gains and the running row sum
  logic signed [31:0] alpha_q = ALPHA_RST;
  logic signed [31:0] beta_q = BETA_RST;
  logic signed [63:0] dot_acc = '0;
  bit                 dot_overflow = 1'b0;

  row_out_t row_results_due[$];
  int       result_mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       cycle_count = 0;

  matrix_vector_multiply_add_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // random backpressure on the result side
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic flag_mismatch(input string msg);
    result_mismatches++;
    if (result_mismatches <= 10) $display("%s", msg);
  endtask

  // compare each accepted result with the oldest expected row
  always @(posedge clk) begin : check_rows
    row_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (row_results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected row result %h sat %b", out_tdata, out_tuser[0]));
      end else begin
        want = row_results_due.pop_front();
        if (out_tdata !== want.row_result || out_tuser[0] !== want.saturated)
          flag_mismatch($sformatf("row result: expected %h sat %b, got %h sat %b",
                                  want.row_result, want.saturated, out_tdata, out_tuser[0]));
      end
    end
  end

  // one accepted request: accumulate floor(m*v / 2^16), finish the row on last
  function automatic void predict_row_step(input logic signed [31:0] m, v, bias,
                                           input bit last);
    logic signed [127:0] mw, vw, bw, aw, gw, accw, term, sum;
    logic signed [127:0] hi, lo, ah, rest, total, lim_hi, lim_lo;
    row_out_t r;
    mw = m;
    vw = v;
    bw = bias;
    accw = dot_acc;
    term = (mw * vw) >>> 16;
    sum = accw + term;
    lim_hi = ACC_MAX;
    lim_lo = ACC_MIN;
    if (sum > lim_hi) begin
      dot_acc = ACC_MAX;
      dot_overflow = 1'b1;
    end else if (sum < lim_lo) begin
      dot_acc = ACC_MIN;
      dot_overflow = 1'b1;
    end else begin
      dot_acc = sum[63:0];
    end
    if (!last) return;

    // split the accumulator so alpha*acc never needs more than 64 bits
    aw = alpha_q;
    gw = beta_q;
    accw = dot_acc;
    hi = accw >>> 32;
    lo = {96'd0, dot_acc[31:0]};
    ah = aw * hi;
    rest = ((aw * lo) >>> 16) + ((gw * bw) >>> 16);
    lim_hi = RES_MAX;
    lim_lo = RES_MIN;
    r.saturated = 1'b0;
    if (ah > 128'sh1_0000_0000) begin
      total = lim_hi;
      r.saturated = 1'b1;
    end else if (ah < -128'sh1_0000_0000) begin
      total = lim_lo;
      r.saturated = 1'b1;
    end else begin
      total = ah * 128'sd65536 + rest;
      if (total > lim_hi) begin
        total = lim_hi;
        r.saturated = 1'b1;
      end else if (total < lim_lo) begin
        total = lim_lo;
        r.saturated = 1'b1;
      end
    end
    r.row_result = total[31:0];
    r.saturated = r.saturated | dot_overflow;
    row_results_due.push_back(r);
    dot_acc = '0;
    dot_overflow = 1'b0;
  endfunction

  // send one request; starts and ends at a falling edge
  task automatic send_element(input logic signed [31:0] m, v, bias, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {bias, v, m};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    predict_row_step(m, v, bias, last);
    @(negedge clk);
  endtask

  // hold off until every expected row is out and the block has settled
  task automatic wait_until_drained();
    in_tvalid = 1'b0;
    while (row_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_gain(input cfg_idx_t idx, input logic [31:0] value);
    wait_until_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      IDX_ALPHA: alpha_q = value;
      IDX_BETA:  beta_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // operand mix: limits, zero, full range and values near unity
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(9))
      0: return RES_MIN;
      1: return RES_MAX;
      2: return '0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(4))
      0: return $urandom;
      1: return Q_ONE;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // gains as they come out of reset; bias is ignored with beta at zero
  task automatic test_default_gains();
    send_element(Q_ONE, 32'sh0002_0000, 32'sh0005_0000, 1'b1);
    send_element(Q_HALF, 32'sh0003_0000, RES_MIN, 1'b0);
    send_element(-32'sh0001_8000, 32'sh0002_0000, RES_MAX, 1'b1);
  endtask

  // operand limits, floor rounding of negative products
  task automatic test_operand_extremes();
    send_element(RES_MIN, RES_MIN, '0, 1'b1);
    send_element(RES_MAX, RES_MAX, '0, 1'b1);
    send_element(RES_MIN, RES_MAX, '0, 1'b1);
    send_element('0, RES_MIN, RES_MAX, 1'b1);
    send_element(-32'sd1, -32'sd1, '0, 1'b1);
    send_element(-32'sd1, 32'sd1, '0, 1'b1);
  endtask

  // gain limits, clamping through alpha*acc and through beta*bias
  task automatic test_gain_extremes();
    write_gain(IDX_ALPHA, RES_MAX);
    write_gain(IDX_BETA, RES_MAX);
    send_element(RES_MAX, RES_MAX, RES_MAX, 1'b1);
    send_element(Q_ONE, Q_ONE, RES_MIN, 1'b1);
    write_gain(IDX_ALPHA, RES_MIN);
    write_gain(IDX_BETA, RES_MIN);
    send_element(RES_MIN, RES_MIN, RES_MIN, 1'b1);
    send_element(-32'sd1, 32'sd1, 32'sd1, 1'b1);
    write_gain(IDX_ALPHA, -Q_ONE);
    write_gain(IDX_BETA, Q_HALF);
    send_element(32'sh0003_0000, 32'sh0002_0000, -32'sh0004_0000, 1'b1);
    write_gain(IDX_ALPHA, '0);
    write_gain(IDX_BETA, Q_ONE);
    send_element(RES_MAX, RES_MAX, RES_MAX, 1'b1);
  endtask

  // writes to unused indexes leave both gains alone
  task automatic test_spare_index();
    write_gain(IDX_SPARE_A, $urandom);
    write_gain(IDX_SPARE_B, $urandom);
    send_element(32'sh0002_0000, 32'sh0002_0000, Q_ONE, 1'b1);
    write_gain(IDX_ALPHA, ALPHA_RST);
    write_gain(IDX_BETA, BETA_RST);
  endtask

  // rows of random length with gain changes and full drains in between
  task automatic run_random_rows(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int row_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      row_len = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int k = 0; k < row_len; k++) begin
        send_element(pick_q16(), pick_q16(), pick_q16(), k == row_len - 1);
        sent++;
      end
      case ($urandom_range(15))
        0: write_gain(IDX_ALPHA, pick_gain());
        1: write_gain(IDX_BETA, pick_gain());
        2: write_gain(($urandom_range(1) != 0) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
        3: wait_until_drained();
        default: ;
      endcase
    end
  endtask

  // long back-to-back rows of large terms: the high word grows past what alpha can scale
  task automatic test_long_rows();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gain(IDX_ALPHA, Q_ONE);
    write_gain(IDX_BETA, Q_HALF);
    for (int n = 0; n < LONG_ROW_LEN; n++) send_element(RES_MIN, RES_MIN, '0, 1'b0);
    send_element(RES_MIN, RES_MAX, RES_MAX, 1'b1);
    for (int n = 0; n < LONG_ROW_LEN; n++) send_element(RES_MIN, RES_MAX, '0, 1'b0);
    send_element(RES_MIN, RES_MIN, RES_MIN, 1'b1);
    // zero alpha leaves only the bias term
    write_gain(IDX_ALPHA, '0);
    for (int n = 0; n < LONG_ROW_LEN; n++) send_element(RES_MAX, RES_MAX, '0, 1'b0);
    send_element(Q_ONE, Q_ONE, RES_MIN, 1'b1);
    write_gain(IDX_ALPHA, Q_ONE);
    send_element(RES_MAX, RES_MIN, RES_MIN, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 82;
    test_default_gains();
    test_operand_extremes();
    test_gain_extremes();
    test_spare_index();
    run_random_rows(17, 82, 260);
    run_random_rows(82, 17, 260);
    run_random_rows(0, 0, 260);
    test_long_rows();
    wait_until_drained();
    if (result_mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
